>>> rtl/nprs_pkg.sv
package nprs_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = 6;
  localparam int IdxCapInt = (MaxPoints - 1 > 63) ? 63 : MaxPoints - 1;
  localparam logic [IdxW-1:0] IDX_CAP = IdxW'(IdxCapInt);

  localparam int ScaleW  = 14;
  localparam int OrgW    = 24;
  localparam int DirW    = 15;
  localparam int PointW  = 16;
  localparam int CfgW    = 24;
  localparam int VecW    = 15;
  localparam int SqSumW  = 30;
  localparam int MetricW = 60;

  localparam logic [ScaleW-1:0] SCALE_RESET = ScaleW'(2560);

  typedef enum logic [2:0] {
    CFG_GRID_SCALE   = 3'd0,
    CFG_RAY_ORIGIN_X = 3'd1,
    CFG_RAY_ORIGIN_Y = 3'd2,
    CFG_RAY_ORIGIN_Z = 3'd3,
    CFG_RAY_DIR_X    = 3'd4,
    CFG_RAY_DIR_Y    = 3'd5,
    CFG_RAY_DIR_Z    = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_SQ,
    ST_MUL,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic load;
    logic vec;
    logic sq;
    logic mul;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

  // (p * scale - org * 256) >> 14 with floor, saturated to 15 signed bits
  function automatic logic signed [VecW-1:0] vec_comp(
    input logic signed [PointW-1:0] p,
    input logic [ScaleW-1:0]        scale,
    input logic signed [OrgW-1:0]   org
  );
    logic signed [30:0]     prod;
    logic signed [32:0]     w;
    logic signed [18:0]     v;
    logic signed [VecW-1:0] res;
    prod = p * $signed({1'b0, scale});
    w = 33'(prod) - 33'($signed({org, 8'h00}));
    v = w[32:14];
    if (!v[18] && (v[17:14] != 4'h0)) begin
      res = 15'sh3fff;
    end else if (v[18] && (v[17:14] != 4'hf)) begin
      res = 15'sh4000;
    end else begin
      res = v[14:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/nearest_point_to_ray_select_unit.sv
// Nearest point to a pick ray.
// Input channel: one candidate point per item (in_point_x/y/z, grid Q8.8)
// plus in_last_point, which closes the pick. Taken when in_valid is high
// and in_stall is low. Points get indices 0, 1, 2, ... in arrival order;
// the index holds at 63 once reached.
// Result channel: on the last point of a pick one item, out_nearest_index,
// is offered with out_valid and taken when out_stall is low. Other points
// give no result.
// Config: cfg_wr_en / cfg_index / cfg_data write grid scale, ray origin and
// ray direction; write them between picks.
// Timing: each item runs through a five-step sequence (accept, offset
// vector, squares and dot product, wide products, compare), and the next
// point is taken only once the compare step has finished; the result
// register is loaded in the compare step. If an earlier result is still
// stalled, a last point waits in the compare step and in_stall stays high.
// Reset (synchronous, rst_n low): config returns to scale 2560, zero origin
// and direction; the pick state and the result valid flag are cleared.
module nearest_point_to_ray_select_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_index,
  input  logic [nprs_pkg::CfgW-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [nprs_pkg::PointW-1:0]  in_point_x,
  input  logic signed [nprs_pkg::PointW-1:0]  in_point_y,
  input  logic signed [nprs_pkg::PointW-1:0]  in_point_z,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nprs_pkg::IdxW-1:0]           out_nearest_index
);
  import nprs_pkg::*;

  cmd_t    cmd;
  status_t status;

  nprs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  nprs_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_z        (in_point_z),
    .in_last_point     (in_last_point),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index)
  );

endmodule

>>> rtl/nprs_ctrl.sv
module nprs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nprs_pkg::status_t status,
  output nprs_pkg::cmd_t    cmd
);
  import nprs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_VEC;
        end
      end
      ST_VEC: begin
        cmd.vec   = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // a last item waits here until the result register can take it
        if (!status.last || status.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/nprs_datapath.sv
module nprs_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_index,
  input  logic [nprs_pkg::CfgW-1:0]           cfg_data,
  input  logic signed [nprs_pkg::PointW-1:0]  in_point_x,
  input  logic signed [nprs_pkg::PointW-1:0]  in_point_y,
  input  logic signed [nprs_pkg::PointW-1:0]  in_point_z,
  input  logic                                in_last_point,
  input  nprs_pkg::cmd_t                      cmd,
  output nprs_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nprs_pkg::IdxW-1:0]           out_nearest_index
);
  import nprs_pkg::*;

  logic [ScaleW-1:0]      scale_r;
  logic signed [OrgW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [DirW-1:0] dir_x_r, dir_y_r, dir_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_SCALE:   scale_r <= cfg_data[ScaleW-1:0];
        CFG_RAY_ORIGIN_X: org_x_r <= cfg_data[OrgW-1:0];
        CFG_RAY_ORIGIN_Y: org_y_r <= cfg_data[OrgW-1:0];
        CFG_RAY_ORIGIN_Z: org_z_r <= cfg_data[OrgW-1:0];
        CFG_RAY_DIR_X:    dir_x_r <= cfg_data[DirW-1:0];
        CFG_RAY_DIR_Y:    dir_y_r <= cfg_data[DirW-1:0];
        CFG_RAY_DIR_Z:    dir_z_r <= cfg_data[DirW-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [PointW-1:0] px_r, py_r, pz_r;
  logic                     last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (cmd.load) begin
      last_r <= in_last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
      pz_r <= in_point_z;
    end
  end

  // offset vector from ray origin
  logic signed [VecW-1:0] vx_r, vy_r, vz_r;

  always_ff @(posedge clk) begin
    if (cmd.vec) begin
      vx_r <= vec_comp(px_r, scale_r, org_x_r);
      vy_r <= vec_comp(py_r, scale_r, org_y_r);
      vz_r <= vec_comp(pz_r, scale_r, org_z_r);
    end
  end

  // squared lengths and dot product
  logic signed [29:0]     sq_vx, sq_vy, sq_vz, sq_dx, sq_dy, sq_dz;
  logic signed [29:0]     pr_x, pr_y, pr_z;
  logic signed [31:0]     vd;
  logic [SqSumW-1:0]      vv_nxt, dd_nxt, vd_abs_nxt;
  logic [SqSumW-1:0]      vv_r, dd_r, vd_abs_r;

  always_comb begin
    sq_vx = vx_r * vx_r;
    sq_vy = vy_r * vy_r;
    sq_vz = vz_r * vz_r;
    sq_dx = dir_x_r * dir_x_r;
    sq_dy = dir_y_r * dir_y_r;
    sq_dz = dir_z_r * dir_z_r;
    pr_x  = vx_r * dir_x_r;
    pr_y  = vy_r * dir_y_r;
    pr_z  = vz_r * dir_z_r;
    vv_nxt = SqSumW'(sq_vx[28:0]) + SqSumW'(sq_vy[28:0]) + SqSumW'(sq_vz[28:0]);
    dd_nxt = SqSumW'(sq_dx[28:0]) + SqSumW'(sq_dy[28:0]) + SqSumW'(sq_dz[28:0]);
    vd     = 32'(pr_x) + 32'(pr_y) + 32'(pr_z);
    vd_abs_nxt = vd[31] ? SqSumW'(-vd) : vd[SqSumW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      vv_r     <= vv_nxt;
      dd_r     <= dd_nxt;
      vd_abs_r <= vd_abs_nxt;
    end
  end

  // |d|^2 |v|^2 and (v.d)^2
  logic [MetricW-1:0] prod_a_r, prod_b_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_a_r <= dd_r * vv_r;
      prod_b_r <= vd_abs_r * vd_abs_r;
    end
  end

  // running minimum
  logic [MetricW-1:0] metric;
  logic [MetricW-1:0] best_r, best_nxt;
  logic [IdxW-1:0]    best_pos_r, best_pos_nxt, win_pos;
  logic [IdxW-1:0]    cnt_r, cnt_nxt;
  logic               take;
  logic               out_valid_r, out_valid_nxt;
  logic [IdxW-1:0]    out_idx_r, out_idx_nxt;

  always_comb begin
    metric       = prod_a_r - prod_b_r;
    take         = (cnt_r == '0) || (metric < best_r);
    win_pos      = take ? cnt_r : best_pos_r;
    best_nxt     = best_r;
    best_pos_nxt = best_pos_r;
    cnt_nxt      = cnt_r;
    out_idx_nxt  = out_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.upd) begin
      if (last_r) begin
        best_nxt      = '0;
        best_pos_nxt  = '0;
        cnt_nxt       = '0;
        out_idx_nxt   = win_pos;
        out_valid_nxt = 1'b1;
      end else begin
        if (take) begin
          best_nxt     = metric;
          best_pos_nxt = cnt_r;
        end
        if (cnt_r < IDX_CAP) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      best_pos_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      best_r      <= best_nxt;
      best_pos_r  <= best_pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
  end

  assign status.last       = last_r;
  assign status.out_free   = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;

endmodule

>>> sim/nprs_pick_checker.sv
module nprs_pick_checker
  import nprs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [2:0]               cfg_index,
  input  logic [CfgW-1:0]          cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [PointW-1:0] in_point_x,
  input  logic signed [PointW-1:0] in_point_y,
  input  logic signed [PointW-1:0] in_point_z,
  input  logic                     in_last_point,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [IdxW-1:0]          out_nearest_index,
  output int                       fail_count,
  output int                       pending
);

  logic [ScaleW-1:0]      scale_q;
  logic signed [OrgW-1:0] org_q [3];
  logic signed [DirW-1:0] dir_q [3];

  logic [IdxW-1:0]     slot_cnt;
  logic [IdxW-1:0]     best_slot;
  longint unsigned     best_dist;
  logic [IdxW-1:0]     winner_queue [$];
  int                  mismatches;

  // world offset of one coordinate, floored >> 14 and clamped to 15 signed bits
  function automatic longint ray_offset(input logic signed [PointW-1:0] p,
                                        input logic signed [OrgW-1:0] org);
    longint w;
    w = longint'(p) * longint'(scale_q) - longint'(org) * 256;
    w = w >>> 14;
    if (w > 16383) begin
      w = 16383;
    end else if (w < -16384) begin
      w = -16384;
    end
    return w;
  endfunction

  // |d|^2 |v|^2 - (v.d)^2, never negative
  function automatic longint unsigned ray_distance(input logic signed [PointW-1:0] px,
                                                   input logic signed [PointW-1:0] py,
                                                   input logic signed [PointW-1:0] pz);
    longint          v [3];
    longint          d;
    longint          vd;
    longint unsigned dd;
    longint unsigned vv;
    v[0] = ray_offset(px, org_q[0]);
    v[1] = ray_offset(py, org_q[1]);
    v[2] = ray_offset(pz, org_q[2]);
    dd = 0;
    vv = 0;
    vd = 0;
    for (int i = 0; i < 3; i++) begin
      d  = longint'(dir_q[i]);
      dd = dd + longint'(d * d);
      vv = vv + longint'(v[i] * v[i]);
      vd = vd + v[i] * d;
    end
    return dd * vv - longint'(vd * vd);
  endfunction

  always @(posedge clk) begin
    longint unsigned cand_metric;
    logic [IdxW-1:0] want;
    if (!rst_n) begin
      scale_q   = SCALE_RESET;
      org_q     = '{default: '0};
      dir_q     = '{default: '0};
      slot_cnt  = '0;
      best_slot = '0;
      best_dist = 0;
      winner_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GRID_SCALE:   scale_q  = cfg_data[ScaleW-1:0];
          CFG_RAY_ORIGIN_X: org_q[0] = cfg_data[OrgW-1:0];
          CFG_RAY_ORIGIN_Y: org_q[1] = cfg_data[OrgW-1:0];
          CFG_RAY_ORIGIN_Z: org_q[2] = cfg_data[OrgW-1:0];
          CFG_RAY_DIR_X:    dir_q[0] = cfg_data[DirW-1:0];
          CFG_RAY_DIR_Y:    dir_q[1] = cfg_data[DirW-1:0];
          CFG_RAY_DIR_Z:    dir_q[2] = cfg_data[DirW-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        cand_metric = ray_distance(in_point_x, in_point_y, in_point_z);
        if (slot_cnt == '0 || cand_metric < best_dist) begin
          best_dist = cand_metric;
          best_slot = slot_cnt;
        end
        if (slot_cnt < IDX_CAP) begin
          slot_cnt = slot_cnt + 1'b1;
        end
        if (in_last_point) begin
          winner_queue.push_back(best_slot);
          slot_cnt  = '0;
          best_slot = '0;
          best_dist = 0;
        end
      end

      if (out_valid && !out_stall) begin
        if (winner_queue.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: nearest_index %0d with nothing pending",
                     out_nearest_index);
          end
          mismatches++;
        end else begin
          want = winner_queue.pop_front();
          if (out_nearest_index !== want) begin
            if (mismatches < 10) begin
              $display("nearest_index mismatch: expected %0d, got %0d",
                       want, out_nearest_index);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= winner_queue.size();
  end

  initial mismatches = 0;

endmodule

>>> sim/tb_top.sv
module tb_top;
  import nprs_pkg::*;

  localparam int IdleLimit   = 3000;
  localparam int SettleWait  = 12;
  localparam int TailWait    = 20;
  localparam int HoldCycles  = 400;
  localparam int HoldAfter   = 25;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 160;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [2:0]               cfg_index;
  logic [CfgW-1:0]          cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [PointW-1:0] in_point_x;
  logic signed [PointW-1:0] in_point_y;
  logic signed [PointW-1:0] in_point_z;
  logic                     in_last_point;
  logic                     out_valid;
  logic                     out_stall;
  logic [IdxW-1:0]          out_nearest_index;

  int fail_count;
  int pending;
  int quiet_cycles;
  bit idle_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  nearest_point_to_ray_select_unit dut (.*);

  nprs_pick_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_z        (in_point_z),
    .in_last_point     (in_last_point),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // watchdog: cycles with no handshake and no register write
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("nearest_point_to_ray_select_unit regression: fail");
        $finish;
      end
    end
  end

  // result side: random stall per item when idle_on is set, one long hold-off to back up the block
  initial begin
    int  n;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = idle_on ? $urandom_range(0, 10) : 0;
      if (!held && taken >= HoldAfter) begin
        n    = HoldCycles;
        held = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_point(input int x, input int y, input int z, input bit last);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= PointW'(x);
    in_point_y    <= PointW'(y);
    in_point_z    <= PointW'(z);
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain all results, then give a trailing non-last item time to finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgW'(val);
    @(posedge clk);
  endtask

  task automatic load_ray(input int sc, input int ox, input int oy, input int oz,
                          input int dx, input int dy, input int dz, input bit junk_write);
    put_reg(CFG_GRID_SCALE, sc);
    put_reg(CFG_RAY_ORIGIN_X, ox);
    put_reg(CFG_RAY_ORIGIN_Y, oy);
    put_reg(CFG_RAY_ORIGIN_Z, oz);
    put_reg(CFG_RAY_DIR_X, dx);
    put_reg(CFG_RAY_DIR_Y, dy);
    put_reg(CFG_RAY_DIR_Z, dz);
    if (junk_write) begin
      put_reg(CFG_UNUSED, $urandom);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int rand_origin();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    end else if (r < 8) begin
      return $urandom;
    end
    return 0;
  endfunction

  function automatic int rand_dir(input int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 16383))
                                            : -int'($urandom_range(1, 16384));
      2: return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_ray();
    int sc;
    int mode;
    int axis;
    int d [3];
    bit noisy;
    case ($urandom_range(0, 4))
      0: sc = 256;
      1: sc = 12800;
      4: sc = $urandom_range(0, 16383);
      default: sc = $urandom_range(256, 12800);
    endcase
    noisy = $urandom_range(0, 1);
    mode  = $urandom_range(0, 9);
    axis  = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      if (mode == 0) begin
        d[i] = rand_dir(0);
      end else if (mode < 3) begin
        // axis-aligned ray
        d[i] = (i == axis) ? rand_dir(1) : 0;
      end else if (mode < 5) begin
        d[i] = rand_dir(2);
      end else begin
        d[i] = rand_dir(3);
      end
      // junk above the field width must be dropped
      if (noisy) begin
        d[i] = (d[i] & 32'h7fff) | (int'($urandom) << DirW);
      end
    end
    if (noisy) begin
      sc = sc | (int'($urandom) << ScaleW);
    end
    load_ray(sc, rand_origin(), rand_origin(), rand_origin(), d[0], d[1], d[2], noisy);
  endtask

  initial begin
    int sent;
    int len;
    int r;
    int cx, cy, cz;
    int px, py, pz;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_point_x    <= '0;
    in_point_y    <= '0;
    in_point_z    <= '0;
    in_last_point <= 1'b0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: zero direction, index 0 wins
    send_point(100, 200, 300, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(-5, 5, -5, 1'b1);
    settle();

    // field extremes, saturating offsets
    load_ray(12800, 8388607, -8388608, 0, 16383, -16384, 1, 1'b0);
    send_point(32767, -32768, 0, 1'b0);
    send_point(-32768, 32767, -1, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(1, -1, 32767, 1'b1);
    send_point(-32768, -32768, -32768, 1'b1);
    settle();

    // ray along z: points on the ray tie at zero, first one kept
    load_ray(256, 0, 0, 0, 0, 0, 16383, 1'b0);
    send_point(0, 0, 5000, 1'b0);
    send_point(0, 0, -5000, 1'b0);
    send_point(3000, 0, 0, 1'b1);
    send_point(0, 0, 0, 1'b1);
    send_point(400, 400, 0, 1'b0);
    send_point(100, 100, 100, 1'b0);
    settle();

    // rewrite mid-pick, plus a write to the unused index
    load_ray(16383, -1, 1, -8388608, -16384, -16384, -16384, 1'b1);
    send_point(7, 7, 7, 1'b0);
    send_point(0, 0, 0, 1'b1);
    settle();

    // zero scale: every point maps to the same offset
    load_ray(0, 300, -300, 77, 5, -3, 2, 1'b0);
    send_point(1000, -2000, 3000, 1'b0);
    send_point(-32768, 32767, 0, 1'b1);
    settle();

    px = 0;
    py = 0;
    pz = 0;
    for (int ph = 0; ph < RandPhases; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_ray();
      sent = 0;
      while (sent < PhaseItems) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 10);
        cx = int'($urandom_range(0, 8000)) - 4000;
        cy = int'($urandom_range(0, 8000)) - 4000;
        cz = int'($urandom_range(0, 8000)) - 4000;
        for (int k = 0; k < len && sent < PhaseItems; k++) begin
          r = $urandom_range(0, 19);
          if (r < 6) begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
          end else if (r < 17) begin
            // cluster around a center so metrics compete closely
            px = cx + int'($urandom_range(0, 128)) - 64;
            py = cy + int'($urandom_range(0, 128)) - 64;
            pz = cz + int'($urandom_range(0, 128)) - 64;
          end else if (r == 19) begin
            px = 0;
            py = 0;
            pz = 0;
          end
          // r in 17..18 repeats the previous point: exact tie
          send_point(px, py, pz, k == len - 1);
          sent++;
        end
      end
      settle();
    end

    do @(posedge clk); while (pending != 0);
    repeat (TailWait) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("nearest_point_to_ray_select_unit regression: pass");
    end else begin
      $display("nearest_point_to_ray_select_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> nearest_point_to_ray_select_unit.f
rtl/nprs_pkg.sv
rtl/nprs_ctrl.sv
rtl/nprs_datapath.sv
rtl/nearest_point_to_ray_select_unit.sv
sim/nprs_pick_checker.sv
sim/tb_top.sv
